// ----- hdl/lbf_pkg.sv -----
package lbf_pkg;

  // Configuration port geometry.
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 24;

  // Register indexes on the configuration port.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE   = 3'd0,
    CFG_MODE     = 3'd1,
    CFG_PEAK     = 3'd2,
    CFG_LEFT     = 3'd3,
    CFG_RIGHT    = 3'd4,
    CFG_INTERVAL = 3'd5
  } cfg_idx_t;

  // Effect modes that need decoding; any other enabled mode shows a solid frame.
  localparam logic [1:0] MODE_OFF     = 2'd0;
  localparam logic [1:0] MODE_BREATHE = 2'd2;

  // Input item codes.
  localparam logic FUNC_TICK    = 1'b0;
  localparam logic FUNC_CHANGED = 1'b1;

  localparam logic [15:0] INTERVAL_RESET = 16'd40;

  // Breathe period of 3000 ms is split as 8 * 375: the low three bits of the
  // time pass straight through, the rest is reduced modulo 375 by reciprocal.
  localparam logic [8:0]  DIV_375    = 9'd375;
  localparam logic [29:0] RECIP_375  = 30'd733007752;  // ceil(2^38 / 375)
  localparam int unsigned RECIP_375_SH = 38;

  localparam logic [11:0] HALF_PERIOD = 12'd1500;
  localparam logic [11:0] FULL_PERIOD = 12'd3000;

  // Level factor is 4500 + 17 * d, scaled by peak and divided by 30000.
  // 30000 = 16 * 1875: shift by four, then reciprocal of 1875.
  localparam logic [14:0] LEVEL_BASE    = 15'd4500;
  localparam logic [19:0] RECIP_1875    = 20'd572663;  // ceil(2^30 / 1875)
  localparam int unsigned RECIP_1875_SH = 30;

  // Configuration register file.
  typedef struct packed {
    logic        enable;
    logic [1:0]  mode;
    logic [7:0]  peak;
    logic [23:0] left_color;
    logic [23:0] right_color;
    logic [15:0] interval;
  } cfg_t;

  // Item handed from the decision stage to the level pipeline.
  typedef struct packed {
    logic        breathe;
    logic        blank;
    logic [28:0] nsh;
    logic [2:0]  low3;
    logic [58:0] prod;
  } lbf_s1_t;

endpackage

// ----- hdl/lbf_in_if.sv -----
interface lbf_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] now_ms;

  modport source(output valid, func, now_ms, input ready);
  modport sink(input valid, func, now_ms, output ready);
endinterface

// ----- hdl/lbf_out_if.sv -----
interface lbf_out_if;
  logic       valid;
  logic       ready;
  logic       blank;
  logic [7:0] brightness;
  logic [7:0] left_red;
  logic [7:0] left_green;
  logic [7:0] left_blue;
  logic [7:0] right_red;
  logic [7:0] right_green;
  logic [7:0] right_blue;

  modport source(output valid, blank, brightness, left_red, left_green, left_blue,
                 right_red, right_green, right_blue, input ready);
  modport sink(input valid, blank, brightness, left_red, left_green, left_blue,
               right_red, right_green, right_blue, output ready);
endinterface

// ----- hdl/lbf_ctrl.sv -----
module lbf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  lbf_pkg::cfg_t   cfg,
  lbf_in_if.sink          item_in,
  input  logic            ld2,
  output logic            v1,
  output lbf_pkg::lbf_s1_t s1
);

  logic        v0;
  logic        func0;
  logic [31:0] now0;
  logic        ld0;
  logic        ld1;
  logic        take;

  logic [31:0] last_frame_ms;
  logic [31:0] last_frame_ms_next;
  logic        refresh_pending;
  logic        refresh_pending_next;

  logic        emit;
  logic        blank;
  logic        breathe;
  logic [31:0] elapsed;
  logic        due;
  logic [28:0] nsh;

  // Each stage loads when it is empty or its contents move on.
  assign ld1 = !v1 || ld2;
  assign ld0 = !v0 || ld1;
  assign item_in.ready = ld0;
  assign take = v0 && ld1;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (ld0) begin
      v0 <= item_in.valid;
    end
    if (ld0 && item_in.valid) begin
      func0 <= item_in.func;
      now0  <= item_in.now_ms;
    end
  end

  // Frame decision against the timer and the pending flag.
  assign elapsed = now0 - last_frame_ms;
  assign due     = elapsed >= {16'd0, cfg.interval};

  always_comb begin
    emit                 = 1'b0;
    blank                = 1'b0;
    breathe              = 1'b0;
    last_frame_ms_next   = last_frame_ms;
    refresh_pending_next = refresh_pending;
    if (func0 == lbf_pkg::FUNC_CHANGED) begin
      last_frame_ms_next   = now0;
      refresh_pending_next = 1'b1;
    end else if (cfg.enable && cfg.mode == lbf_pkg::MODE_BREATHE) begin
      if (due) begin
        last_frame_ms_next = now0;
        emit               = 1'b1;
        breathe            = 1'b1;
      end
    end else if (refresh_pending) begin
      refresh_pending_next = 1'b0;
      emit                 = 1'b1;
      blank                = !cfg.enable || cfg.mode == lbf_pkg::MODE_OFF;
    end
  end

  // Timer and pending flag advance as each item leaves the input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_frame_ms   <= '0;
      refresh_pending <= 1'b1;
    end else if (take) begin
      last_frame_ms   <= last_frame_ms_next;
      refresh_pending <= refresh_pending_next;
    end
  end

  // First stage of the modulo: time divided by eight, times the reciprocal of 375.
  assign nsh = now0[31:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (ld1) begin
      v1 <= take && emit;
    end
    if (ld1) begin
      s1.breathe <= breathe;
      s1.blank   <= blank;
      s1.nsh     <= nsh;
      s1.low3    <= now0[2:0];
      s1.prod    <= nsh * lbf_pkg::RECIP_375;
    end
  end

endmodule

// ----- hdl/lbf_level.sv -----
module lbf_level (
  input  logic             clk,
  input  logic             rst,
  input  lbf_pkg::cfg_t    cfg,
  input  logic             v1,
  input  lbf_pkg::lbf_s1_t s1,
  output logic             ld2,
  lbf_out_if.source        frame
);

  logic        ld3;
  logic        ld4;
  logic        ldo;

  logic        v2;
  logic        breathe2;
  logic        blank2;
  logic [2:0]  low3_2;
  logic [8:0]  rem2;

  logic        v3;
  logic        breathe3;
  logic        blank3;
  logic [22:0] y3;

  logic        v4;
  logic        breathe4;
  logic        blank4;
  logic [38:0] prod4;

  logic [20:0] quot;
  logic [28:0] qm;
  logic [28:0] rem_raw;
  logic [28:0] rem_fix;
  logic [11:0] phase;
  logic [10:0] fold;
  logic [14:0] factor;
  logic [7:0]  level;
  logic [7:0]  bright;
  logic        lit;

  assign ldo = !frame.valid || frame.ready;
  assign ld4 = !v4 || ldo;
  assign ld3 = !v3 || ld4;
  assign ld2 = !v2 || ld3;

  // Remainder modulo 375 from the estimated quotient, with one correction step.
  assign quot    = s1.prod[58:lbf_pkg::RECIP_375_SH];
  assign qm      = 29'(quot * lbf_pkg::DIV_375);
  assign rem_raw = s1.nsh - qm;
  assign rem_fix = (rem_raw >= {20'd0, lbf_pkg::DIV_375}) ?
                   rem_raw - {20'd0, lbf_pkg::DIV_375} : rem_raw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (ld2) begin
      v2 <= v1;
    end
    if (ld2) begin
      breathe2 <= s1.breathe;
      blank2   <= s1.blank;
      low3_2   <= s1.low3;
      rem2     <= rem_fix[8:0];
    end
  end

  // Triangle distance within the period, then the peak-scaled factor.
  assign phase  = {rem2, low3_2};
  assign fold   = (phase < lbf_pkg::HALF_PERIOD) ? phase[10:0] :
                  11'(lbf_pkg::FULL_PERIOD - phase);
  assign factor = lbf_pkg::LEVEL_BASE + ({4'd0, fold} << 4) + {4'd0, fold};

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (ld3) begin
      v3 <= v2;
    end
    if (ld3) begin
      breathe3 <= breathe2;
      blank3   <= blank2;
      y3       <= cfg.peak * factor;
    end
  end

  // Division by 30000: drop four bits, then multiply by the reciprocal of 1875.
  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (ld4) begin
      v4 <= v3;
    end
    if (ld4) begin
      breathe4 <= breathe3;
      blank4   <= blank3;
      prod4    <= y3[22:4] * lbf_pkg::RECIP_1875;
    end
  end

  // Result register; a static frame carries the peak or nothing.
  assign level  = prod4[lbf_pkg::RECIP_1875_SH +: 8];
  assign bright = breathe4 ? level : (blank4 ? 8'd0 : cfg.peak);
  assign lit    = !blank4;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame.valid <= 1'b0;
    end else if (ldo) begin
      frame.valid <= v4;
    end
    if (ldo && v4) begin
      frame.blank       <= blank4;
      frame.brightness  <= bright;
      frame.left_red    <= lit ? cfg.left_color[23:16]  : 8'd0;
      frame.left_green  <= lit ? cfg.left_color[15:8]   : 8'd0;
      frame.left_blue   <= lit ? cfg.left_color[7:0]    : 8'd0;
      frame.right_red   <= lit ? cfg.right_color[23:16] : 8'd0;
      frame.right_green <= lit ? cfg.right_color[15:8]  : 8'd0;
      frame.right_blue  <= lit ? cfg.right_color[7:0]   : 8'd0;
    end
  end

endmodule

// ----- hdl/led_breathe_frame_generator.sv -----
// Channel    Direction  Payload
// item_in    in         func, now_ms
// frame      out        blank, brightness, left/right red, green, blue
// cfg        in         cfg_we, cfg_index, cfg_data (write only)
//
// One item is taken every cycle unless a full pipeline holds the input; a frame
// passes the input register, two stages of the modulo, two of the level scaling,
// then the result register. Reset is synchronous; it empties the pipeline, sets
// the pending-refresh flag and the 40 ms interval. Each stage holds only while
// the one after it is full, so items keep entering while a frame waits to be
// taken, until the stages before the result register fill.
module led_breathe_frame_generator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [lbf_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [lbf_pkg::CfgDataW-1:0]  cfg_data,
  lbf_in_if.sink                        item_in,
  lbf_out_if.source                     frame
);

  lbf_pkg::cfg_t    cfg;
  lbf_pkg::lbf_s1_t s1;
  logic             v1;
  logic             ld2;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable      <= 1'b0;
      cfg.mode        <= lbf_pkg::MODE_OFF;
      cfg.peak        <= '0;
      cfg.left_color  <= '0;
      cfg.right_color <= '0;
      cfg.interval    <= lbf_pkg::INTERVAL_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lbf_pkg::CFG_ENABLE:   cfg.enable      <= cfg_data[0];
        lbf_pkg::CFG_MODE:     cfg.mode        <= cfg_data[1:0];
        lbf_pkg::CFG_PEAK:     cfg.peak        <= cfg_data[7:0];
        lbf_pkg::CFG_LEFT:     cfg.left_color  <= cfg_data[23:0];
        lbf_pkg::CFG_RIGHT:    cfg.right_color <= cfg_data[23:0];
        lbf_pkg::CFG_INTERVAL: cfg.interval    <= cfg_data[15:0];
        default: begin
        end
      endcase
    end
  end

  // Decision and timer state.
  lbf_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .item_in (item_in),
    .ld2     (ld2),
    .v1      (v1),
    .s1      (s1)
  );

  // Breathe level pipeline and result register.
  lbf_level u_level (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg),
    .v1    (v1),
    .s1    (s1),
    .ld2   (ld2),
    .frame (frame)
  );

endmodule
